// ===== hw/rtl/ciee_pkg.sv =====
package ciee_pkg;

    localparam int unsigned LEN_W   = 28;
    localparam int unsigned COORD_W = 32;
    localparam int unsigned KIND_W  = 3;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [31:0] CIEE_MAX_EVENTS = 32'd65535;

    localparam logic [KIND_W-1:0] OP_CONSUME = 3'd0;
    localparam logic [KIND_W-1:0] OP_INS     = 3'd1;
    localparam logic [KIND_W-1:0] OP_DEL     = 3'd2;
    localparam logic [KIND_W-1:0] OP_SCLIP   = 3'd3;
    localparam logic [KIND_W-1:0] OP_HCLIP   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_EVENT_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_END_BASES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEL_SELECT  = 2'd2;

    localparam logic REC_EVENT = 1'b0;
    localparam logic REC_COUNT = 1'b1;
    localparam logic EV_DEL    = 1'b0;
    localparam logic EV_INS    = 1'b1;

    localparam int unsigned SEL_DEL_BIT = 0;
    localparam int unsigned SEL_INS_BIT = 1;

    typedef struct packed {
        logic [KIND_W-1:0]  op_kind;
        logic [LEN_W-1:0]   op_len;
        logic               first_op;
        logic               last_op;
        logic [COORD_W-1:0] read_len;
        logic [COORD_W-1:0] ref_start;
        logic [LEN_W-1:0]   end_clip_len;
    } op_item_t;

    typedef struct packed {
        logic               record_kind;
        logic [COORD_W-1:0] event_start;
        logic [COORD_W-1:0] event_end;
        logic [LEN_W-1:0]   event_size;
        logic               event_kind;
        logic [COUNT_W-1:0] event_count;
        logic               last;
    } res_item_t;

    typedef struct packed {
        logic      ev_valid;
        res_item_t ev;
        logic      cnt_valid;
        res_item_t cnt;
    } res_pair_t;

endpackage

// ===== hw/rtl/ciee_stream_if.sv =====
interface ciee_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/ciee_in_stage.sv =====
module ciee_in_stage
    import ciee_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  op_item_t in_item,
    output logic     in_ready,
    input  logic     advance,
    output logic     item_valid,
    output op_item_t item
);

    logic     valid_reg;
    logic     valid_next;
    op_item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== hw/rtl/ciee_core.sv =====
module ciee_core
    import ciee_pkg::*;
#(
    parameter logic [31:0] MAX_EVENTS = CIEE_MAX_EVENTS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  advance,
    input  op_item_t              item,
    output res_pair_t             pair
);

    localparam logic [COUNT_W-1:0] EVENT_CAP =
        (MAX_EVENTS > 32'd65535) ? 16'hFFFF : MAX_EVENTS[COUNT_W-1:0];

    logic [LEN_W-1:0]   min_event_len_reg;
    logic [COORD_W-1:0] min_end_bases_reg;
    logic [1:0]         indel_select_reg;

    logic [COORD_W-1:0] ref_coord_reg, ref_coord_next;
    logic [COORD_W-1:0] query_bases_reg, query_bases_next;
    logic [COORD_W-1:0] stop_limit_reg, stop_limit_next;
    logic               scan_finished_reg, scan_finished_next;
    logic [COUNT_W-1:0] events_found_reg, events_found_next;

    logic [COORD_W-1:0] rc, qb, ef_unused_guard;
    logic [COUNT_W-1:0] ef;
    logic               fin;
    logic [COORD_W-1:0] len32, clip32, sclip32, rc_add, qb_add;
    logic [COORD_W-1:0] ev_start, ev_end;
    logic               ev_kind, test, emit;

    assign len32   = {{(COORD_W-LEN_W){1'b0}}, item.op_len};
    assign clip32  = {{(COORD_W-LEN_W){1'b0}}, item.end_clip_len};
    assign sclip32 = (item.op_kind == OP_SCLIP) ? len32 : '0;

    always_comb
    begin
        rc  = item.first_op ? item.ref_start : ref_coord_reg;
        qb  = item.first_op ? '0 : query_bases_reg;
        ef  = item.first_op ? '0 : events_found_reg;
        fin = item.first_op ? 1'b0 : scan_finished_reg;
        stop_limit_next = item.first_op
            ? (item.read_len - min_end_bases_reg - clip32 - sclip32)
            : stop_limit_reg;
        ef_unused_guard = '0;
    end

    assign rc_add = rc + len32;
    assign qb_add = qb + len32;

    always_comb
    begin
        ref_coord_next     = rc;
        query_bases_next   = qb;
        scan_finished_next = fin;
        ev_start           = rc;
        ev_end             = rc + 32'd1;
        ev_kind            = EV_INS;
        test               = 1'b0;
        emit               = 1'b0;
        if (!fin && item.op_kind != OP_SCLIP && item.op_kind != OP_HCLIP)
        begin
            if (item.op_kind == OP_DEL)
            begin
                ref_coord_next = rc_add;
                ev_end         = rc_add - 32'd1;
                ev_kind        = EV_DEL;
                test           = indel_select_reg[SEL_DEL_BIT];
            end
            else if (item.op_kind == OP_INS)
            begin
                query_bases_next = qb_add;
                test = (qb >= min_end_bases_reg) && indel_select_reg[SEL_INS_BIT];
            end
            else
            begin
                query_bases_next = qb_add;
                ref_coord_next   = rc_add;
            end
            if (test)
            begin
                if (query_bases_next >= stop_limit_next)
                begin
                    scan_finished_next = 1'b1;
                end
                else
                begin
                    emit = (query_bases_next >= min_end_bases_reg)
                        && (item.op_len >= min_event_len_reg)
                        && (ef < EVENT_CAP);
                end
            end
        end
        events_found_next = ef + {{(COUNT_W-1){1'b0}}, emit};
    end

    always_comb
    begin
        pair.ev_valid        = emit;
        pair.ev.record_kind  = REC_EVENT;
        pair.ev.event_start  = ev_start;
        pair.ev.event_end    = ev_end | ef_unused_guard;
        pair.ev.event_size   = item.op_len;
        pair.ev.event_kind   = ev_kind;
        pair.ev.event_count  = '0;
        pair.ev.last         = !item.last_op;
        pair.cnt_valid       = item.last_op;
        pair.cnt.record_kind = REC_COUNT;
        pair.cnt.event_start = '0;
        pair.cnt.event_end   = '0;
        pair.cnt.event_size  = '0;
        pair.cnt.event_kind  = EV_DEL;
        pair.cnt.event_count = events_found_next;
        pair.cnt.last        = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_event_len_reg <= '0;
            min_end_bases_reg <= '0;
            indel_select_reg  <= 2'b11;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MIN_EVENT_LEN: min_event_len_reg <= cfg_data[LEN_W-1:0];
                CFG_MIN_END_BASES: min_end_bases_reg <= cfg_data[COORD_W-1:0];
                CFG_INDEL_SELECT:  indel_select_reg  <= cfg_data[1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_coord_reg     <= '0;
            query_bases_reg   <= '0;
            stop_limit_reg    <= '0;
            scan_finished_reg <= 1'b0;
            events_found_reg  <= '0;
        end
        else if (advance)
        begin
            ref_coord_reg     <= ref_coord_next;
            query_bases_reg   <= query_bases_next;
            stop_limit_reg    <= stop_limit_next;
            scan_finished_reg <= scan_finished_next;
            events_found_reg  <= events_found_next;
        end
    end

endmodule

// ===== hw/rtl/ciee_res_queue.sv =====
module ciee_res_queue
    import ciee_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  res_pair_t pair,
    output logic      room,
    output logic      out_valid,
    input  logic      out_ready,
    output res_item_t out_item
);

    localparam int unsigned DEPTH = 4;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = PTR_W + 1;

    res_item_t         mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [PTR_W-1:0]  cnt_addr;
    logic              pop, push_ev, push_cnt;
    logic [CNT_W-1:0]  push_n;

    assign pop      = out_valid && out_ready;
    assign push_ev  = push && pair.ev_valid;
    assign push_cnt = push && pair.cnt_valid;
    assign push_n   = CNT_W'(push_ev) + CNT_W'(push_cnt);
    assign cnt_addr = wr_ptr_reg + PTR_W'(push_ev);

    assign room = (count_reg <= CNT_W'(DEPTH - 2))
        || ((count_reg == CNT_W'(DEPTH - 1)) && pop);

    assign wr_ptr_next = wr_ptr_reg + push_n[PTR_W-1:0];
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + push_n - CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ev)
        begin
            mem[wr_ptr_reg] <= pair.ev;
        end
        if (push_cnt)
        begin
            mem[cnt_addr] <= pair.cnt;
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_item  = mem[rd_ptr_reg];

endmodule

// ===== hw/rtl/cigar_indel_event_extractor_unit.sv =====
// An accepted item is registered in the input stage, then its results go into
// the result queue. Throughput: 1 item per cycle while the 4-entry queue has
// room for two results; an item with an event and a count record writes both
// at once. The read state is registered per item, so items follow back to back.
// Reset (rst_n, async, active low) clears read state, queue and input stage,
// and loads min_event_len = 0, min_end_bases = 0, indel_select = 3.
module cigar_indel_event_extractor_unit
    import ciee_pkg::*;
#(
    parameter logic [31:0] MAX_EVENTS = CIEE_MAX_EVENTS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    ciee_stream_if.sink           op_in,
    ciee_stream_if.source         res_out
);

    logic      item_valid;
    op_item_t  item;
    logic      room;
    logic      advance;
    res_pair_t pair;

    assign advance = item_valid && room;

    ciee_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (op_in.valid),
        .in_item    (op_in.payload),
        .in_ready   (op_in.ready),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    ciee_core #(
        .MAX_EVENTS (MAX_EVENTS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (advance),
        .item      (item),
        .pair      (pair)
    );

    ciee_res_queue u_res_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (advance),
        .pair      (pair),
        .room      (room),
        .out_valid (res_out.valid),
        .out_ready (res_out.ready),
        .out_item  (res_out.payload)
    );

endmodule

// ===== hw/rtl/ciee_checker.sv =====
module ciee_checker
    import ciee_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_ready,
    input res_item_t out_item
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    a_count_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.record_kind == REC_COUNT |->
            out_item.last && out_item.event_size == '0)
        else $error("count record malformed");

    a_event_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.record_kind == REC_EVENT |-> out_item.event_count == '0)
        else $error("event carries a count");

    a_ins_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.record_kind == REC_EVENT && out_item.event_kind == EV_INS
            |-> out_item.event_end == out_item.event_start + 32'd1)
        else $error("insertion end mismatch");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result right after reset");

endmodule

bind cigar_indel_event_extractor_unit ciee_checker u_ciee_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (res_out.valid),
    .out_ready (res_out.ready),
    .out_item  (res_out.payload)
);
